/* rtl/core/q4sg_pkg.sv */
// Shared types and constants of the Q4 shape gradient block.
// Used by q4sg_div and q4_shape_gradient_global; depends on nothing.
package q4sg_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int N_LANES = 8;
	localparam int GRAD_W = 32;
	localparam int NUM_W = 48;
	localparam int DEN_W = 64;
	localparam int QUOT_BITS = 33;
	localparam int DIV_LAT = QUOT_BITS + 2;

	localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
	localparam logic signed [34:0] JAC_MAX = 35'sd2147483647;

	typedef struct packed {
		logic signed [15:0] local_xi;
		logic signed [15:0] local_eta;
		logic signed [31:0] node0_x;
		logic signed [31:0] node0_y;
		logic signed [31:0] node1_x;
		logic signed [31:0] node1_y;
		logic signed [31:0] node2_x;
		logic signed [31:0] node2_y;
		logic signed [31:0] node3_x;
		logic signed [31:0] node3_y;
	} item_t;

	typedef struct packed {
		logic signed [31:0] grad_n0_x;
		logic signed [31:0] grad_n0_y;
		logic signed [31:0] grad_n1_x;
		logic signed [31:0] grad_n1_y;
		logic signed [31:0] grad_n2_x;
		logic signed [31:0] grad_n2_y;
		logic signed [31:0] grad_n3_x;
		logic signed [31:0] grad_n3_y;
		logic               out_of_element;
		logic               singular_map;
	} result_t;

endpackage

/* rtl/core/q4sg_div.sv */
// Pipelined restoring divider lane: one quotient bit per stage, round and saturate.
// Depends on q4sg_pkg.
module q4sg_div #(
	parameter int NUM_W = q4sg_pkg::NUM_W,
	parameter int SH = 2 * q4sg_pkg::COORD_FRAC_BITS_DEF - 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [NUM_W-1:0]                  num,
	input  logic [q4sg_pkg::DEN_W-1:0]        den,
	input  logic                              neg,
	output logic signed [q4sg_pkg::GRAD_W-1:0] quot
);

	localparam int QB = q4sg_pkg::QUOT_BITS;
	localparam int DW = q4sg_pkg::DEN_W;
	localparam int GW = q4sg_pkg::GRAD_W;
	localparam int VW = NUM_W + SH + 1;
	localparam int HW = VW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [VW-1:0] dvd_c;
	logic [CW-1:0] hi_c;
	logic [CW-1:0] den_c;
	logic          ovf_c;

	logic [DW-1:0] rem_s [QB];
	logic [QB-1:0] low_s [QB];
	logic [QB-1:0] quo_s [QB+1];
	logic [DW-1:0] den_s [QB];
	logic          ovf_s [QB+1];
	logic          neg_s [QB+1];

	logic [DW:0]   t_c [QB];
	logic [DW:0]   d_c [QB];
	logic          ge_c [QB];

	logic [GW-1:0] qhi_c;
	logic [GW:0]   mag_c;
	logic signed [GW-1:0] res_c;
	logic signed [GW-1:0] quot_q;

	assign dvd_c = {num, {(SH + 1){1'b0}}};
	assign hi_c = CW'(dvd_c[VW-1:QB]);
	assign den_c = CW'(den);
	assign ovf_c = hi_c >= den_c;

	always_comb begin
		for (int i = 0; i < QB; i++) begin
			t_c[i] = {rem_s[i], low_s[i][QB-1]};
			d_c[i] = t_c[i] - {1'b0, den_s[i]};
			ge_c[i] = t_c[i] >= {1'b0, den_s[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf_c ? '0 : hi_c[DW-1:0];
			low_s[0] <= dvd_c[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= ovf_c;
			neg_s[0] <= neg;
			for (int i = 1; i < QB; i++) begin
				rem_s[i] <= ge_c[i-1] ? d_c[i-1][DW-1:0] : t_c[i-1][DW-1:0];
				low_s[i] <= {low_s[i-1][QB-2:0], 1'b0};
				den_s[i] <= den_s[i-1];
			end
			for (int i = 1; i <= QB; i++) begin
				quo_s[i] <= {quo_s[i-1][QB-2:0], ge_c[i-1]};
				ovf_s[i] <= ovf_s[i-1];
				neg_s[i] <= neg_s[i-1];
			end
			quot_q <= res_c;
		end
	end

	always_comb begin
		qhi_c = quo_s[QB][QB-1:1];
		mag_c = {1'b0, qhi_c} + (GW + 1)'(quo_s[QB][0]);
		if (neg_s[QB]) begin
			if (ovf_s[QB] || mag_c > {2'b01, {(GW - 1){1'b0}}})
				res_c = {1'b1, {(GW - 1){1'b0}}};
			else
				res_c = -mag_c[GW-1:0];
		end else begin
			if (ovf_s[QB] || mag_c > {2'b00, {(GW - 1){1'b1}}})
				res_c = {1'b0, {(GW - 1){1'b1}}};
			else
				res_c = mag_c[GW-1:0];
		end
	end

	assign quot = quot_q;

endmodule

/* rtl/core/q4_shape_gradient_global.sv */
// Top level of the Q4 shape gradient block: Jacobian, determinant and eight divider lanes.
// Depends on q4sg_pkg and q4sg_div.
//
// Usage:
//   The item channel carries a reference point (Q1.14) and the four node coordinates;
//   the result channel carries the eight global gradients and two flags.
//   Both channels transfer when valid is high and stall is low.
//   One item can be taken every cycle while the output is not stalled; a result passes
//   through five stages of shape derivatives, Jacobian and determinant products,
//   numerators and magnitudes, 35 stages of the one-bit-per-stage divider lanes,
//   and the output register.
//   A point outside the element gives out_of_element and zero gradients; a zero
//   determinant for a point inside it gives singular_map and zero gradients.
//   When the receiver stalls a waiting result, the whole pipeline holds and item_stall
//   rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline starts empty and takes items at once.
module q4_shape_gradient_global #(
	parameter int COORD_FRAC_BITS = q4sg_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  q4sg_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output q4sg_pkg::result_t result
);

	localparam int SH = 2 * COORD_FRAC_BITS - 16;
	localparam int NL = q4sg_pkg::N_LANES;
	localparam int NW = q4sg_pkg::NUM_W;
	localparam int DW = q4sg_pkg::DEN_W;
	localparam int GW = q4sg_pkg::GRAD_W;
	localparam int DL = q4sg_pkg::DIV_LAT;

	function automatic logic signed [31:0] jac_round(input logic signed [50:0] s);
		logic signed [50:0] t;
		logic signed [34:0] r;
		t = s + 51'sd32768;
		r = t[50:16];
		if (r > q4sg_pkg::JAC_MAX)
			return 32'sd2147483647;
		else if (r < -q4sg_pkg::JAC_MAX)
			return -32'sd2147483647;
		else
			return r[31:0];
	endfunction

	logic adv;

	logic signed [31:0] px_c [4];
	logic signed [31:0] py_c [4];
	logic signed [16:0] xi_c, eta_c;
	logic signed [16:0] gxi_c [4];
	logic signed [16:0] geta_c [4];
	logic signed [48:0] pa_c [4], pb_c [4], pc_c [4], pd_c [4];
	logic               oob_c;

	logic               vld_s1, oob_s1;
	logic signed [16:0] gxi_s1 [4], geta_s1 [4];
	logic signed [48:0] pa_s1 [4], pb_s1 [4], pc_s1 [4], pd_s1 [4];

	logic               vld_s2, oob_s2;
	logic signed [16:0] gxi_s2 [4], geta_s2 [4];
	logic signed [31:0] a_s2, b_s2, c_s2, d_s2;

	logic               vld_s3, oob_s3;
	logic signed [63:0] ad_s3, bc_s3;
	logic signed [48:0] dg_s3 [4], cg_s3 [4], ag_s3 [4], bg_s3 [4];

	logic               vld_s4, oob_s4;
	logic signed [63:0] det_s4;
	logic signed [49:0] num_s4 [NL];

	logic signed [49:0] abs_c [NL];
	logic [DW-1:0]      den_c;

	logic               vld_s5, oob_s5, sing_s5;
	logic [NW-1:0]      mag_s5 [NL];
	logic               neg_s5 [NL];
	logic [DW-1:0]      den_s5;

	logic               vld_d [DL];
	logic               oob_d [DL];
	logic               sing_d [DL];

	logic signed [GW-1:0] quot_c [NL];
	logic                 zero_c;
	q4sg_pkg::result_t    res_c;
	q4sg_pkg::result_t    result_q;
	logic                 result_vld_q;

	assign adv = !(result_vld_q && result_stall);
	assign item_stall = !adv;

	always_comb begin
		px_c[0] = item.node0_x; py_c[0] = item.node0_y;
		px_c[1] = item.node1_x; py_c[1] = item.node1_y;
		px_c[2] = item.node2_x; py_c[2] = item.node2_y;
		px_c[3] = item.node3_x; py_c[3] = item.node3_y;
		xi_c = {item.local_xi[15], item.local_xi};
		eta_c = {item.local_eta[15], item.local_eta};
		oob_c = (xi_c > q4sg_pkg::ONE_Q14) || (xi_c < -q4sg_pkg::ONE_Q14) ||
			(eta_c > q4sg_pkg::ONE_Q14) || (eta_c < -q4sg_pkg::ONE_Q14);
		gxi_c[0] = eta_c - q4sg_pkg::ONE_Q14;
		geta_c[0] = xi_c - q4sg_pkg::ONE_Q14;
		gxi_c[1] = q4sg_pkg::ONE_Q14 - eta_c;
		geta_c[1] = -q4sg_pkg::ONE_Q14 - xi_c;
		gxi_c[2] = q4sg_pkg::ONE_Q14 + eta_c;
		geta_c[2] = q4sg_pkg::ONE_Q14 + xi_c;
		gxi_c[3] = -q4sg_pkg::ONE_Q14 - eta_c;
		geta_c[3] = q4sg_pkg::ONE_Q14 - xi_c;
		for (int k = 0; k < 4; k++) begin
			pa_c[k] = px_c[k] * gxi_c[k];
			pb_c[k] = px_c[k] * geta_c[k];
			pc_c[k] = py_c[k] * gxi_c[k];
			pd_c[k] = py_c[k] * geta_c[k];
		end
	end

	always_comb begin
		for (int j = 0; j < NL; j++)
			abs_c[j] = num_s4[j][49] ? -num_s4[j] : num_s4[j];
		den_c = det_s4[63] ? DW'(-det_s4) : DW'(det_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int i = 0; i < DL; i++)
				vld_d[i] <= 1'b0;
			result_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_d[0] <= vld_s5;
			for (int i = 1; i < DL; i++)
				vld_d[i] <= vld_d[i-1];
			result_vld_q <= vld_d[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oob_s1 <= oob_c;
			for (int k = 0; k < 4; k++) begin
				gxi_s1[k] <= gxi_c[k];
				geta_s1[k] <= geta_c[k];
				pa_s1[k] <= pa_c[k];
				pb_s1[k] <= pb_c[k];
				pc_s1[k] <= pc_c[k];
				pd_s1[k] <= pd_c[k];
			end

			oob_s2 <= oob_s1;
			gxi_s2 <= gxi_s1;
			geta_s2 <= geta_s1;
			a_s2 <= jac_round(51'(pa_s1[0]) + 51'(pa_s1[1]) + 51'(pa_s1[2]) + 51'(pa_s1[3]));
			b_s2 <= jac_round(51'(pb_s1[0]) + 51'(pb_s1[1]) + 51'(pb_s1[2]) + 51'(pb_s1[3]));
			c_s2 <= jac_round(51'(pc_s1[0]) + 51'(pc_s1[1]) + 51'(pc_s1[2]) + 51'(pc_s1[3]));
			d_s2 <= jac_round(51'(pd_s1[0]) + 51'(pd_s1[1]) + 51'(pd_s1[2]) + 51'(pd_s1[3]));

			oob_s3 <= oob_s2;
			ad_s3 <= a_s2 * d_s2;
			bc_s3 <= b_s2 * c_s2;
			for (int k = 0; k < 4; k++) begin
				dg_s3[k] <= d_s2 * gxi_s2[k];
				cg_s3[k] <= c_s2 * geta_s2[k];
				ag_s3[k] <= a_s2 * geta_s2[k];
				bg_s3[k] <= b_s2 * gxi_s2[k];
			end

			oob_s4 <= oob_s3;
			det_s4 <= ad_s3 - bc_s3;
			for (int k = 0; k < 4; k++) begin
				num_s4[2*k] <= 50'(dg_s3[k]) - 50'(cg_s3[k]);
				num_s4[2*k+1] <= 50'(ag_s3[k]) - 50'(bg_s3[k]);
			end

			oob_s5 <= oob_s4;
			sing_s5 <= !oob_s4 && (det_s4 == 64'sd0);
			den_s5 <= den_c;
			for (int j = 0; j < NL; j++) begin
				mag_s5[j] <= abs_c[j][NW-1:0];
				neg_s5[j] <= num_s4[j][49] ^ det_s4[63];
			end

			oob_d[0] <= oob_s5;
			sing_d[0] <= sing_s5;
			for (int i = 1; i < DL; i++) begin
				oob_d[i] <= oob_d[i-1];
				sing_d[i] <= sing_d[i-1];
			end

			result_q <= res_c;
		end
	end

	for (genvar j = 0; j < NL; j++) begin : g_lane
		q4sg_div #(
			.NUM_W(NW),
			.SH(SH)
		) u_div (
			.clk(clk),
			.en(adv),
			.num(mag_s5[j]),
			.den(den_s5),
			.neg(neg_s5[j]),
			.quot(quot_c[j])
		);
	end

	always_comb begin
		zero_c = oob_d[DL-1] || sing_d[DL-1];
		res_c.grad_n0_x = zero_c ? '0 : quot_c[0];
		res_c.grad_n0_y = zero_c ? '0 : quot_c[1];
		res_c.grad_n1_x = zero_c ? '0 : quot_c[2];
		res_c.grad_n1_y = zero_c ? '0 : quot_c[3];
		res_c.grad_n2_x = zero_c ? '0 : quot_c[4];
		res_c.grad_n2_y = zero_c ? '0 : quot_c[5];
		res_c.grad_n3_x = zero_c ? '0 : quot_c[6];
		res_c.grad_n3_y = zero_c ? '0 : quot_c[7];
		res_c.out_of_element = oob_d[DL-1];
		res_c.singular_map = sing_d[DL-1];
	end

	assign result = result_q;
	assign result_valid = result_vld_q;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.out_of_element && result.singular_map))
		else $error("out_of_element and singular_map both set");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.out_of_element || result.singular_map) |->
		result.grad_n0_x == 0 && result.grad_n0_y == 0 && result.grad_n1_x == 0 &&
		result.grad_n1_y == 0 && result.grad_n2_x == 0 && result.grad_n2_y == 0 &&
		result.grad_n3_x == 0 && result.grad_n3_y == 0)
		else $error("flagged result carries nonzero gradient");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> vld_s1)
		else $error("transferred item missing from first stage");

	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s5) && $stable(vld_d[DL-1]))
		else $error("pipeline moved while output stalled");

endmodule
